// ===== hw/rtl/vpcm_pkg.sv =====
`timescale 1ns / 1ps

package vpcm_pkg;

  // table depth and derived index widths
  localparam int MAX_GROUPS = 8;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);

  // field widths
  localparam int CELL_W  = 16;
  localparam int PITCH_W = 24;
  localparam int POS_W   = 32;

  // serial multiplier: cell count (one bit wider than a cell number) times pitch
  localparam int MUL_A_W = CELL_W + 1;
  localparam int PROD_W  = MUL_A_W + PITCH_W;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_LOAD      = 2'd1,
    CMD_TO_CELL   = 2'd2,
    CMD_TO_CENTER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // one table row
  typedef struct packed {
    logic [CELL_W-1:0]  first;
    logic [CELL_W-1:0]  last;
    logic [PITCH_W-1:0] pitch;
    logic [POS_W-1:0]   offset;
  } grp_t;

  typedef struct packed {
    logic          en;
    logic [GW-1:0] addr;
    grp_t          data;
  } tbl_wr_t;

endpackage

// ===== hw/rtl/vpcm_table.sv =====
`timescale 1ns / 1ps

module vpcm_table (
  input  logic                     clk,
  input  vpcm_pkg::tbl_wr_t        wr,
  input  logic [vpcm_pkg::GW-1:0]  rd_addr,
  output vpcm_pkg::grp_t           rd_data
);
  import vpcm_pkg::*;

  grp_t mem [MAX_GROUPS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/vpcm_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module vpcm_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [vpcm_pkg::MUL_A_W-1:0]    a,
  input  logic [vpcm_pkg::PITCH_W-1:0]    b,
  output logic                            done,
  output logic [vpcm_pkg::PROD_W-1:0]     prod
);
  import vpcm_pkg::*;

  localparam int NW = $clog2(MUL_A_W);

  logic              busy;
  logic [NW-1:0]     cnt;
  logic [PITCH_W:0]  upper;

  assign upper = {1'b0, prod[PROD_W-1:MUL_A_W]} + (prod[0] ? {1'b0, b} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(MUL_A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{PITCH_W{1'b0}}, a};
    end else if (busy) begin
      prod <= {upper, prod[MUL_A_W-1:1]};
    end
  end

endmodule

// ===== hw/rtl/vpcm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in CELL_W bits, so the upper dividend half starts below the divisor.
module vpcm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [vpcm_pkg::POS_W-1:0]      dividend,
  input  logic [vpcm_pkg::PITCH_W-1:0]    divisor,
  output logic                            done,
  output logic [vpcm_pkg::CELL_W-1:0]     quot
);
  import vpcm_pkg::*;

  localparam int NW = $clog2(CELL_W);

  logic               busy;
  logic [NW-1:0]      cnt;
  logic [PITCH_W-1:0] rem;
  logic [PITCH_W:0]   shifted;
  logic [PITCH_W:0]   trial;

  assign shifted = {rem, quot[CELL_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(CELL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= PITCH_W'(dividend[POS_W-1:CELL_W]);
      quot <= dividend[CELL_W-1:0];
    end else if (busy) begin
      if (!trial[PITCH_W]) begin
        rem  <= trial[PITCH_W-1:0];
        quot <= {quot[CELL_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[PITCH_W-1:0];
        quot <= {quot[CELL_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/variable_pitch_cell_mapper.sv =====
`timescale 1ns / 1ps

// Variable-pitch cell mapper for one sensor axis built from up to MAX_GROUPS
// cell groups, each with its own pitch in nm. Commands: clear the table, load
// a group (groups must come in ascending cell order), map a coordinate (nm,
// relative to the sensor center) to a cell, and map a cell to its center
// coordinate. Every item gives exactly one result item. One item is worked
// at a time; a finished result sits in the output register, so the next item
// is taken while it waits. Clear, lookups on an empty table, clamped or
// upper-edge coordinates and loads rejected up front finish in the decode
// state; a load that reaches the multiplier runs a serial multiply of cell
// count by pitch, coordinate to cell walks the table (a request and a check
// state per group), then a serial divide, and cell to center walks the table,
// then the serial multiply. Out-of-sensor coordinates clamp to the first or
// last cell with clamped set.
module variable_pitch_cell_mapper (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic signed [31:0]             coord,
  input  logic [vpcm_pkg::CELL_W-1:0]    cell_req,
  input  logic [vpcm_pkg::CELL_W-1:0]    group_first_cell,
  input  logic [vpcm_pkg::CELL_W-1:0]    group_last_cell,
  input  logic [vpcm_pkg::PITCH_W-1:0]   group_pitch,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vpcm_pkg::CELL_W-1:0]    cell_out,
  output logic signed [31:0]             center_out,
  output logic                           clamped,
  output logic [1:0]                     status
);
  import vpcm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_WREQ = 7'b0000100,
    S_WCHK = 7'b0001000,
    S_POST = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  // S_DONE is folded into a flag so the FSM stays small
  state_t state, state_next;
  logic   res_ready;

  // latched item
  cmd_t               cmd;
  logic [31:0]        coord_q;
  logic [CELL_W-1:0]  cell_q;
  logic [CELL_W-1:0]  gfirst_q;
  logic [CELL_W-1:0]  glast_q;
  logic [PITCH_W-1:0] gpitch_q;

  // table summary
  logic [CW-1:0]      group_count;
  logic [POS_W-1:0]   total_size;
  logic [CELL_W-1:0]  first_first;  // first cell of group 0
  logic [CELL_W-1:0]  last_last;    // last cell of newest group

  // walk
  logic [GW-1:0]      walk_idx;
  logic [POS_W-1:0]   upos;
  logic               found;
  logic [CELL_W-1:0]  cand_first;
  logic [PITCH_W-1:0] cand_pitch;
  logic [POS_W-1:0]   cand_off;

  // staged result
  logic [CELL_W-1:0]  res_cell;
  logic [31:0]        res_center;
  logic               res_clamped;
  status_t            res_status;

  tbl_wr_t            tbl_wr;
  grp_t               rd;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [PITCH_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic               div_start, div_done;
  logic [CELL_W-1:0]  quot;

  logic               accept;
  logic               out_free;
  logic               walk_last;
  logic               load_bad;
  logic signed [33:0] pos;
  logic [PROD_W:0]    new_total;
  logic               load_fits;
  logic [31:0]        center_sum;

  assign in_stall = (state != S_IDLE) || res_ready;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // position from lower edge: coord + floor(total/2)
  assign pos = {{2{coord_q[31]}}, coord_q} + $signed({2'b00, 1'b0, total_size[POS_W-1:1]});

  assign load_bad = (glast_q < gfirst_q) || (gpitch_q == '0) ||
                    ((group_count != '0) && (gfirst_q <= last_last));

  assign walk_last = (CW'(walk_idx) == group_count - CW'(1));

  assign new_total = {{(PROD_W + 1 - POS_W){1'b0}}, total_size} + {1'b0, prod};
  assign load_fits = (new_total[PROD_W:POS_W] == '0);

  assign center_sum = cand_off + prod[31:0] + 32'({cand_pitch[PITCH_W-1:1]})
                    - {1'b0, total_size[POS_W-1:1]};

  // multiplier operands: cell count x pitch for a load, cell index x pitch otherwise
  assign mul_start = ((state == S_DEC) && (cmd == CMD_LOAD) &&
                      (group_count != CW'(MAX_GROUPS)) && !load_bad) ||
                     ((state == S_POST) && (cmd == CMD_TO_CENTER) && found);
  assign mul_a = (cmd == CMD_LOAD) ? (MUL_A_W'(glast_q - gfirst_q) + MUL_A_W'(1))
                                   : MUL_A_W'(cell_q - cand_first);
  assign mul_b = (cmd == CMD_LOAD) ? gpitch_q : cand_pitch;

  assign div_start = (state == S_POST) && (cmd == CMD_TO_CELL);

  // table write on an accepted load
  always_comb begin
    tbl_wr.en          = (state == S_MUL) && mul_done && (cmd == CMD_LOAD) && load_fits;
    tbl_wr.addr        = group_count[GW-1:0];
    tbl_wr.data.first  = gfirst_q;
    tbl_wr.data.last   = glast_q;
    tbl_wr.data.pitch  = gpitch_q;
    tbl_wr.data.offset = total_size;
  end

  vpcm_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (walk_idx),
    .rd_data (rd)
  );

  vpcm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  vpcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (upos - cand_off),
    .divisor  (cand_pitch),
    .done     (div_done),
    .quot     (quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_IDLE;
        if (mul_start) begin
          state_next = S_MUL;
        end else if ((group_count != '0) && (cmd == CMD_TO_CENTER)) begin
          state_next = S_WREQ;
        end else if ((group_count != '0) && (cmd == CMD_TO_CELL) && !pos[33] &&
                     (pos[32:0] < {1'b0, total_size})) begin
          state_next = S_WREQ;
        end
      end
      S_WREQ: state_next = S_WCHK;
      S_WCHK: state_next = walk_last ? S_POST : S_WREQ;
      S_POST: begin
        if (div_start)      state_next = S_DIV;
        else if (mul_start) state_next = S_MUL;
        else                state_next = S_IDLE;
      end
      S_MUL: begin
        if (mul_done) state_next = S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_ready   <= 1'b0;
      group_count <= '0;
      total_size  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // a result is staged whenever a work sequence returns to idle
      if ((state != S_IDLE) && (state_next == S_IDLE)) begin
        res_ready <= 1'b1;
      end else if (res_ready && out_free) begin
        res_ready <= 1'b0;
      end

      if (res_ready && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if ((state == S_DEC) && (cmd == CMD_CLEAR)) begin
        group_count <= '0;
        total_size  <= '0;
      end
      if (tbl_wr.en) begin
        group_count <= group_count + CW'(1);
        total_size  <= new_total[POS_W-1:0];
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= cmd_t'(command);
      coord_q  <= coord;
      cell_q   <= cell_req;
      gfirst_q <= group_first_cell;
      glast_q  <= group_last_cell;
      gpitch_q <= group_pitch;
    end

    if (tbl_wr.en) begin
      last_last <= glast_q;
      if (group_count == '0) first_first <= gfirst_q;
    end

    if (res_ready && out_free) begin
      cell_out   <= res_cell;
      center_out <= res_center;
      clamped    <= res_clamped;
      status     <= res_status;
    end

    unique case (state)
      S_DEC: begin
        walk_idx    <= '0;
        found       <= 1'b0;
        upos        <= pos[31:0];
        res_cell    <= '0;
        res_center  <= '0;
        res_clamped <= 1'b0;
        res_status  <= ST_OK;
        if (cmd == CMD_LOAD) begin
          if (group_count == CW'(MAX_GROUPS)) res_status <= ST_FULL;
          else if (load_bad)                  res_status <= ST_BAD;
        end else if (cmd != CMD_CLEAR) begin
          if (group_count == '0) begin
            res_status <= ST_MISS;
          end else if (cmd == CMD_TO_CELL) begin
            if (pos[33]) begin
              // below the lower edge
              res_cell    <= first_first;
              res_clamped <= 1'b1;
            end else if (pos[32:0] > {1'b0, total_size}) begin
              // beyond the upper edge
              res_cell    <= last_last;
              res_clamped <= 1'b1;
            end else if (pos[32:0] == {1'b0, total_size}) begin
              // exactly on the upper edge
              res_cell <= last_last;
            end
          end
        end
      end
      S_WCHK: begin
        walk_idx <= walk_idx + GW'(1);
        // offsets rise strictly: the last group starting at or below upos holds it
        if (((cmd == CMD_TO_CELL) && (rd.offset <= upos)) ||
            ((cmd == CMD_TO_CENTER) && (cell_q >= rd.first) && (cell_q <= rd.last))) begin
          found      <= 1'b1;
          cand_first <= rd.first;
          cand_pitch <= rd.pitch;
          cand_off   <= rd.offset;
        end
      end
      S_POST: begin
        if ((cmd == CMD_TO_CENTER) && !found) res_status <= ST_MISS;
      end
      S_MUL: begin
        if (mul_done) begin
          if (cmd == CMD_LOAD) begin
            if (!load_fits) res_status <= ST_BAD;
          end else begin
            res_center <= center_sum;
          end
        end
      end
      S_DIV: begin
        if (div_done) res_cell <= quot + cand_first;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sim/cell_mapper_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the cell mapper, predicts one result per accepted
// item and compares results in order.
module cell_mapper_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic signed [31:0]             coord,
  input  logic [vpcm_pkg::CELL_W-1:0]    cell_req,
  input  logic [vpcm_pkg::CELL_W-1:0]    group_first_cell,
  input  logic [vpcm_pkg::CELL_W-1:0]    group_last_cell,
  input  logic [vpcm_pkg::PITCH_W-1:0]   group_pitch,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [vpcm_pkg::CELL_W-1:0]    cell_out,
  input  logic signed [31:0]             center_out,
  input  logic                           clamped,
  input  logic [1:0]                     status,
  output int                             errors,
  output int                             pending
);
  import vpcm_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0]       cell_nr;
    logic signed [POS_W-1:0] center;
    logic                    clamped;
    status_t                 status;
  } map_res_t;

  // shadow of the group table
  grp_t             rows [MAX_GROUPS];
  int unsigned      n_rows;
  logic [POS_W-1:0] size_nm;

  map_res_t pending_results [$];
  map_res_t want;

  function automatic longint unsigned row_span(int unsigned g);
    return (64'(rows[g].last) - 64'(rows[g].first) + 64'd1) * 64'(rows[g].pitch);
  endfunction

  function automatic map_res_t mapped_result(cmd_t cmd, logic signed [31:0] c,
                                             logic [CELL_W-1:0] creq,
                                             logic [CELL_W-1:0] gf,
                                             logic [CELL_W-1:0] gl,
                                             logic [PITCH_W-1:0] gp);
    map_res_t          r;
    longint unsigned   span;
    longint unsigned   upos;
    longint unsigned   off;
    longint            pos;
    bit                hit;
    r   = '0;
    hit = 1'b0;
    span = (64'(gl) - 64'(gf) + 64'd1) * 64'(gp);
    if (cmd == CMD_CLEAR) begin
      n_rows  = 0;
      size_nm = '0;
    end else if (cmd == CMD_LOAD) begin
      if (n_rows >= MAX_GROUPS) begin
        r.status = ST_FULL;
      end else if (gl < gf || gp == '0) begin
        r.status = ST_BAD;
      end else if (n_rows > 0 && gf <= rows[n_rows-1].last) begin
        r.status = ST_BAD;
      end else if (64'(size_nm) + span > 64'hFFFF_FFFF) begin
        r.status = ST_BAD;
      end else begin
        rows[n_rows] = '{first: gf, last: gl, pitch: gp, offset: size_nm};
        size_nm = size_nm + span[31:0];
        n_rows++;
      end
    end else if (n_rows == 0) begin
      r.status = ST_MISS;
    end else if (cmd == CMD_TO_CELL) begin
      pos = longint'(c) + longint'(size_nm >> 1);
      if (pos < 0) begin
        r.cell_nr = rows[0].first;
        r.clamped = 1'b1;
      end else if (longint'(pos) > longint'(64'(size_nm))) begin
        r.cell_nr = rows[n_rows-1].last;
        r.clamped = 1'b1;
      end else begin
        upos = pos;
        for (int unsigned g = 0; g < n_rows; g++) begin
          off = 64'(rows[g].offset);
          if (!hit && upos >= off && upos < off + row_span(g)) begin
            r.cell_nr = 16'((upos - off) / 64'(rows[g].pitch) + 64'(rows[g].first));
            hit       = 1'b1;
          end
        end
        // exactly on the upper edge
        if (!hit) r.cell_nr = rows[n_rows-1].last;
      end
    end else begin
      for (int unsigned g = 0; g < n_rows; g++) begin
        if (!hit && creq >= rows[g].first && creq <= rows[g].last) begin
          r.center = 32'(64'(rows[g].offset)
                       + 64'(rows[g].pitch) * 64'(creq - rows[g].first)
                       + 64'(rows[g].pitch >> 1)
                       - 64'(size_nm >> 1));
          hit = 1'b1;
        end
      end
      if (!hit) r.status = ST_MISS;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      n_rows  = 0;
      size_nm = '0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.insert(pending_results.size(),
                               mapped_result(cmd_t'(command), coord, cell_req,
                                             group_first_cell, group_last_cell,
                                             group_pitch));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item with no item pending");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (cell_out !== want.cell_nr) begin
            $error("cell_out: expected %0d, actual %0d", want.cell_nr, cell_out);
            errors++;
          end
          if (center_out !== want.center) begin
            $error("center_out: expected %0d, actual %0d", want.center, center_out);
            errors++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0d, actual %0d", want.clamped, clamped);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== sim/variable_pitch_cell_mapper_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the cell mapper. Checking lives in
// cell_mapper_checker, which sits beside the block on the same wires.
module variable_pitch_cell_mapper_tb;
  import vpcm_pkg::*;

  localparam int ITEMS          = 1650;
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 100;   // well past the slowest item

  // directed table: 0..9 @ 50 um, 10..19 @ 1 nm, hole 20..99, 100..65535 @ 1 nm
  localparam int DIR_TOTAL = 10 * 50000 + 10 * 1 + 65436 * 1;
  localparam int DIR_HALF  = DIR_TOTAL / 2;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          command = CMD_CLEAR;
  logic signed [31:0]  coord = '0;
  logic [CELL_W-1:0]   cell_req = '0;
  logic [CELL_W-1:0]   group_first_cell = '0;
  logic [CELL_W-1:0]   group_last_cell = '0;
  logic [PITCH_W-1:0]  group_pitch = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CELL_W-1:0]   cell_out;
  logic signed [31:0]  center_out;
  logic                clamped;
  logic [1:0]          status;

  int errors;
  int pending;

  // handshake pressure, in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;

  int items_sent = 0;
  int sent_by_cmd [4] = '{default: 0};
  int quiet_cycles = 0;

  // stimulus-side picture of the table, used only to aim coordinates and cells
  logic [CELL_W-1:0] plan_first [MAX_GROUPS];
  logic [CELL_W-1:0] plan_last [MAX_GROUPS];
  longint unsigned   plan_off [MAX_GROUPS];
  longint unsigned   plan_span [MAX_GROUPS];
  int unsigned       plan_n;
  longint unsigned   plan_total;

  always #2 clk = ~clk;

  variable_pitch_cell_mapper i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .coord            (coord),
    .cell_req         (cell_req),
    .group_first_cell (group_first_cell),
    .group_last_cell  (group_last_cell),
    .group_pitch      (group_pitch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cell_out         (cell_out),
    .center_out       (center_out),
    .clamped          (clamped),
    .status           (status)
  );

  cell_mapper_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .coord            (coord),
    .cell_req         (cell_req),
    .group_first_cell (group_first_cell),
    .group_last_cell  (group_last_cell),
    .group_pitch      (group_pitch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cell_out         (cell_out),
    .center_out       (center_out),
    .clamped          (clamped),
    .status           (status),
    .errors           (errors),
    .pending          (pending)
  );

  // receiver side: random stall, one decision per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: any accepted item on either channel resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("variable_pitch_cell_mapper_tb: done, errors");
        $finish;
      end
    end
  end

  // Present one item and hold it until accepted. An optional idle gap comes
  // first; valid is only ever written once per edge.
  task automatic send_item(cmd_t cmd, logic signed [31:0] c, logic [CELL_W-1:0] creq,
                           logic [CELL_W-1:0] gf, logic [CELL_W-1:0] gl,
                           logic [PITCH_W-1:0] gp);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid         <= 1'b1;
    command          <= cmd;
    coord            <= c;
    cell_req         <= creq;
    group_first_cell <= gf;
    group_last_cell  <= gl;
    group_pitch      <= gp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_by_cmd[cmd]++;
    items_sent++;
  endtask

  // unused fields of each command carry random bits
  task automatic clear_table();
    send_item(CMD_CLEAR, 32'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              24'($urandom));
  endtask

  task automatic load_group(logic [CELL_W-1:0] gf, logic [CELL_W-1:0] gl,
                            logic [PITCH_W-1:0] gp);
    send_item(CMD_LOAD, 32'($urandom), 16'($urandom), gf, gl, gp);
  endtask

  task automatic query_cell(logic signed [31:0] c);
    send_item(CMD_TO_CELL, c, 16'($urandom), 16'($urandom), 16'($urandom),
              24'($urandom));
  endtask

  task automatic query_center(logic [CELL_W-1:0] creq);
    send_item(CMD_TO_CENTER, 32'($urandom), creq, 16'($urandom), 16'($urandom),
              24'($urandom));
  endtask

  initial begin
    int unsigned     n_groups;
    int unsigned     next_cell;
    int unsigned     lc;
    int unsigned     g;
    logic [15:0]     f;
    logic [15:0]     l;
    logic [23:0]     p;
    logic [15:0]     qcell;
    longint unsigned span;
    longint unsigned r;
    longint          pos;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, no idling ----
    // empty table: both lookups miss
    query_cell(32'sd0);
    query_center(16'd0);
    // malformed loads: reversed range, zero pitch
    load_group(16'd5, 16'd4, 24'd100);
    load_group(16'd0, 16'd9, 24'd0);
    load_group(16'd0, 16'd9, 24'd50000);
    // overlaps the previous group
    load_group(16'd9, 16'd20, 24'd10);
    load_group(16'd10, 16'd19, 24'd1);
    // would push the total size past 32 bits
    load_group(16'd100, 16'hFFFF, 24'hFF_FFFF);
    load_group(16'd100, 16'hFFFF, 24'd1);
    // extreme coordinates clamp; edges of the sensor and a group boundary
    query_cell(32'sh8000_0000);
    query_cell(32'sh7FFF_FFFF);
    query_cell(-DIR_HALF);
    query_cell(-DIR_HALF - 1);
    query_cell(DIR_TOTAL - DIR_HALF);
    query_cell(DIR_TOTAL - DIR_HALF + 1);
    query_cell(500000 - DIR_HALF);
    // centers: first cell, hole between groups, top cell, first after hole
    query_center(16'd0);
    query_center(16'd50);
    query_center(16'hFFFF);
    query_center(16'd100);
    // fill the table (max pitch first), then one load too many
    clear_table();
    load_group(16'd0, 16'd0, 24'hFF_FFFF);
    for (int k = 1; k < MAX_GROUPS; k++) load_group(16'(2 * k), 16'(2 * k), 24'(k));
    load_group(16'd20, 16'd20, 24'd5);
    query_center(16'd0);

    // ---- random part: build a well-formed table, then query it ----
    while (items_sent < ITEMS) begin
      // four pressure phases in turn
      case (items_sent * 4 / ITEMS)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 82; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase

      // now and then keep the old table, so loads land on a filled one
      if ($urandom_range(0, 9) != 0) clear_table();
      plan_n     = 0;
      plan_total = 0;
      next_cell  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
      n_groups   = $urandom_range(1, MAX_GROUPS);

      for (int k = 0; k < n_groups && next_cell <= 65535; k++) begin
        f = 16'(next_cell);
        case ($urandom_range(0, 9))
          0:       lc = 65535;
          1, 2:    lc = next_cell + $urandom_range(0, 4095);
          default: lc = next_cell + $urandom_range(0, 63);
        endcase
        if (lc > 65535) lc = 65535;
        l = 16'(lc);
        case ($urandom_range(0, 7))
          0:       p = 24'd1;
          1:       p = 24'hFF_FFFF;
          2, 3:    p = 24'($urandom_range(1, 100));
          default: p = 24'($urandom_range(1, 200000));
        endcase
        span = (64'(l) - 64'(f) + 64'd1) * 64'(p);
        // half the time shrink an oversized group, otherwise let it be rejected
        if (plan_total + span > 64'hFFFF_FFFF && $urandom_range(0, 1) == 0) begin
          p    = 24'd1;
          span = 64'(l) - 64'(f) + 64'd1;
        end
        load_group(f, l, p);
        if (plan_total + span <= 64'hFFFF_FFFF) begin
          plan_first[plan_n] = f;
          plan_last[plan_n]  = l;
          plan_off[plan_n]   = plan_total;
          plan_span[plan_n]  = span;
          plan_total         = plan_total + span;
          plan_n++;
        end
        next_cell = lc + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 500) : 0);
      end

      // extra loads: reversed, zero pitch, overlapping, or the top cell alone
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            lc = $urandom_range(1, 65535);
            load_group(16'(lc), 16'(lc - 1), 24'($urandom_range(1, 1000)));
          end
          1: load_group(16'($urandom), 16'($urandom), 24'd0);
          2: begin
            if (plan_n > 0) load_group(16'(plan_last[plan_n-1] - $urandom_range(0, 3)),
                                       16'hFFFF, 24'd1);
            else load_group(16'd0, 16'd0, 24'd0);
          end
          default: load_group(16'hFFFF, 16'hFFFF, 24'd1);
        endcase
      end

      repeat ($urandom_range(4, 24)) begin
        g = (plan_n > 0) ? $urandom_range(0, plan_n - 1) : 0;
        case ((plan_n > 0) ? $urandom_range(0, 9) : $urandom_range(5, 5))
          0, 1, 2, 3: begin
            // somewhere inside a group
            r   = {$urandom, $urandom};
            pos = longint'(plan_off[g] + r % plan_span[g]);
            query_cell(32'(pos - longint'(plan_total >> 1)));
          end
          4: begin
            // sensor edges and group boundaries, both sides
            case ($urandom_range(0, 6))
              0:       pos = 0;
              1:       pos = -1;
              2:       pos = longint'(plan_off[g]);
              3:       pos = longint'(plan_off[g] + plan_span[g]) - 1;
              4:       pos = longint'(plan_off[g] + plan_span[g]);
              5:       pos = longint'(plan_total);
              default: pos = longint'(plan_total) + 1;
            endcase
            query_cell(32'(pos - longint'(plan_total >> 1)));
          end
          5: query_cell(32'($urandom));
          6, 7, 8: begin
            case ($urandom_range(0, 4))
              0:       qcell = plan_first[g];
              1:       qcell = plan_last[g];
              2:       qcell = plan_first[g] - 16'd1;
              3:       qcell = plan_last[g] + 16'd1;
              default: qcell = 16'(plan_first[g] + $urandom_range(0, plan_last[g] -
                                                                    plan_first[g]));
            endcase
            query_center(qcell);
          end
          default: query_center(16'($urandom));
        endcase
      end

      // a little fully random noise
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(cmd_t'($urandom_range(0, 3)), 32'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 24'($urandom));
      end
    end

    in_valid <= 1'b0;

    // drain: wait for every result, then some quiet cycles to catch extras
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("covered %0d items (%0d clear, %0d load, %0d coord-to-cell, %0d cell-to-center)",
             items_sent, sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_LOAD],
             sent_by_cmd[CMD_TO_CELL], sent_by_cmd[CMD_TO_CENTER]);
    $display("over four phases: free flow, sparse input, heavy output stall, light both");
    if (errors == 0 && pending == 0) begin
      $display("variable_pitch_cell_mapper_tb: done, clean");
    end else begin
      $display("variable_pitch_cell_mapper_tb: done, errors");
    end
    $finish;
  end

endmodule
